// ===== rtl/gregorian_date_day_arithmetic_macros.svh =====
// Assertion macros shared by the date arithmetic block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef GREGORIAN_DATE_DAY_ARITHMETIC_MACROS_SVH
`define GREGORIAN_DATE_DAY_ARITHMETIC_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GDDA_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define GDDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/gdda_pkg.sv =====
// ----------------------------------------------------------------------------
// gdda_pkg
// Shared widths, request codes and controller/datapath signal groups for the
// Gregorian date day arithmetic block.
// ----------------------------------------------------------------------------
package gdda_pkg;

  // Field widths of the request and result transactions.
  localparam int REQ_W   = 2;
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 22;

  // Default width of the internal day counter.
  localparam int COUNT_WIDTH_DEF = 22;

  // Request decoding: the upper code bit selects the difference.
  localparam int                REQ_DIFF_BIT = 1;
  localparam logic [REQ_W-1:0]  REQ_SUB      = 2'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a new request
    logic clamp;   // fix out-of-range days
    logic order;   // put the earlier date first for a difference
    logic step;    // advance one day, or go back one for a subtraction
    logic finish;  // move the outcome into the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;      // stepping has reached its end
    logic limit;     // stepping ended on a range limit or saturation
    logic res_busy;  // result register holds an untaken transaction
  } status_t;

endpackage

// ===== rtl/gdda_ifs.sv =====
// ----------------------------------------------------------------------------
// gdda request and result channels
// Valid/ready channels carrying the request and result transactions.
// ----------------------------------------------------------------------------
interface gdda_req_if;
  logic                          valid;
  logic                          ready;
  logic [gdda_pkg::REQ_W-1:0]    req_type;
  logic [gdda_pkg::DAY_W-1:0]    day_a;
  logic [gdda_pkg::MONTH_W-1:0]  month_a;
  logic [gdda_pkg::YEAR_W-1:0]   year_a;
  logic [gdda_pkg::DAY_W-1:0]    day_b;
  logic [gdda_pkg::MONTH_W-1:0]  month_b;
  logic [gdda_pkg::YEAR_W-1:0]   year_b;
  logic [gdda_pkg::COUNT_W-1:0]  day_count;

  modport source (
    output valid, req_type, day_a, month_a, year_a, day_b, month_b, year_b, day_count,
    input  ready
  );
  modport sink (
    input  valid, req_type, day_a, month_a, year_a, day_b, month_b, year_b, day_count,
    output ready
  );
endinterface

interface gdda_res_if;
  logic                          valid;
  logic                          ready;
  logic [gdda_pkg::DAY_W-1:0]    res_day;
  logic [gdda_pkg::MONTH_W-1:0]  res_month;
  logic [gdda_pkg::YEAR_W-1:0]   res_year;
  logic [gdda_pkg::COUNT_W-1:0]  days_apart;
  logic                          out_of_range;

  modport source (
    output valid, res_day, res_month, res_year, days_apart, out_of_range,
    input  ready
  );
  modport sink (
    input  valid, res_day, res_month, res_year, days_apart, out_of_range,
    output ready
  );
endinterface

// ===== rtl/gdda_dpath.sv =====
// ----------------------------------------------------------------------------
// gdda_dpath
// Date registers, day stepper, day counter and result register of the
// date arithmetic block. Driven by commands from gdda_ctrl.
// ----------------------------------------------------------------------------
`include "gregorian_date_day_arithmetic_macros.svh"

module gdda_dpath #(
  parameter int COUNT_WIDTH = gdda_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  gdda_pkg::cmd_t                cmd,
  output gdda_pkg::status_t             st,
  input  logic [gdda_pkg::REQ_W-1:0]    req_type,
  input  logic [gdda_pkg::DAY_W-1:0]    day_a,
  input  logic [gdda_pkg::MONTH_W-1:0]  month_a,
  input  logic [gdda_pkg::YEAR_W-1:0]   year_a,
  input  logic [gdda_pkg::DAY_W-1:0]    day_b,
  input  logic [gdda_pkg::MONTH_W-1:0]  month_b,
  input  logic [gdda_pkg::YEAR_W-1:0]   year_b,
  input  logic [gdda_pkg::COUNT_W-1:0]  day_count,
  input  logic                          res_ready,
  output logic                          res_valid,
  output logic [gdda_pkg::DAY_W-1:0]    res_day,
  output logic [gdda_pkg::MONTH_W-1:0]  res_month,
  output logic [gdda_pkg::YEAR_W-1:0]   res_year,
  output logic [gdda_pkg::COUNT_W-1:0]  days_apart,
  output logic                          out_of_range
);

  // Only the low bits of the count that both the field and the counter hold matter.
  localparam int CNT_W = (COUNT_WIDTH < gdda_pkg::COUNT_W) ? COUNT_WIDTH : gdda_pkg::COUNT_W;

  localparam logic [gdda_pkg::YEAR_W-1:0]  MAX_YEAR   = 14'd9999;
  localparam logic [gdda_pkg::MONTH_W-1:0] JAN        = 4'd1;
  localparam logic [gdda_pkg::MONTH_W-1:0] FEB        = 4'd2;
  localparam logic [gdda_pkg::MONTH_W-1:0] DEC        = 4'd12;
  localparam logic [gdda_pkg::DAY_W-1:0]   LAST_OF_DEC = 5'd31;
  // Inverse of 25 modulo 2^14 and the largest image of a multiple of 25.
  localparam logic [gdda_pkg::YEAR_W-1:0]  INV25      = 14'd7209;
  localparam logic [gdda_pkg::YEAR_W-1:0]  MUL25_TOP  = 14'd655;

  // Leap rule: divisible by 4 and not by 100, or divisible by 400.
  // A multiple of 4 that is also a multiple of 25 is a multiple of 100.
  function automatic logic leap_year(input logic [gdda_pkg::YEAR_W-1:0] y);
    logic [2*gdda_pkg::YEAR_W-1:0] prod;
    logic                          by25;
    prod = (2*gdda_pkg::YEAR_W)'(y) * (2*gdda_pkg::YEAR_W)'(INV25);
    by25 = (prod[gdda_pkg::YEAR_W-1:0] <= MUL25_TOP);
    return (y[1:0] == 2'd0) && (!by25 || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [gdda_pkg::DAY_W-1:0] month_days(
    input logic [gdda_pkg::MONTH_W-1:0] m,
    input logic                         leap
  );
    logic [gdda_pkg::DAY_W-1:0] n;
    case (m) inside
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      FEB:                     n = leap ? 5'd29 : 5'd28;
      default:                 n = 5'd31;
    endcase
    return n;
  endfunction

  function automatic logic [gdda_pkg::YEAR_W-1:0] fit_year(
    input logic [gdda_pkg::YEAR_W-1:0] y
  );
    return (y > MAX_YEAR) ? MAX_YEAR : y;
  endfunction

  function automatic logic [gdda_pkg::MONTH_W-1:0] fit_month(
    input logic [gdda_pkg::MONTH_W-1:0] m
  );
    logic [gdda_pkg::MONTH_W-1:0] r;
    if (m < JAN) begin
      r = JAN;
    end else if (m > DEC) begin
      r = DEC;
    end else begin
      r = m;
    end
    return r;
  endfunction

  function automatic logic [gdda_pkg::DAY_W-1:0] fit_day(
    input logic [gdda_pkg::DAY_W-1:0] d,
    input logic [gdda_pkg::DAY_W-1:0] ml
  );
    logic [gdda_pkg::DAY_W-1:0] r;
    if (d == 5'd0) begin
      r = 5'd1;
    end else if (d > ml) begin
      r = ml;
    end else begin
      r = d;
    end
    return r;
  endfunction

  logic                          is_diff;
  logic                          is_sub;
  logic [gdda_pkg::DAY_W-1:0]    cur_d, tgt_d;
  logic [gdda_pkg::MONTH_W-1:0]  cur_m, tgt_m;
  logic [gdda_pkg::YEAR_W-1:0]   cur_y, tgt_y;
  logic [CNT_W-1:0]              cnt;

  logic                          leap_cur;
  logic [gdda_pkg::DAY_W-1:0]    ml_cur, ml_tgt, ml_prev;
  logic [gdda_pkg::DAY_W-1:0]    cur_d_next;
  logic [gdda_pkg::MONTH_W-1:0]  cur_m_next;
  logic [gdda_pkg::YEAR_W-1:0]   cur_y_next;
  logic [CNT_W-1:0]              cnt_next;
  logic [CNT_W-1:0]              cnt_less;
  logic                          same_date, a_after_b, at_max, at_min, at_limit, cnt_full;
  logic                          cur_ok;

  // Month lengths of the current date, its previous month and the target date.
  assign leap_cur = leap_year(cur_y);
  assign ml_cur   = month_days(cur_m, leap_cur);
  assign ml_prev  = month_days(cur_m - 4'd1, leap_cur);
  assign ml_tgt   = month_days(tgt_m, leap_year(tgt_y));

  // Date comparisons.
  assign same_date = ({cur_y, cur_m, cur_d} == {tgt_y, tgt_m, tgt_d});
  assign a_after_b = ({cur_y, cur_m, cur_d} > {tgt_y, tgt_m, tgt_d});
  assign at_max    = (cur_y == MAX_YEAR) && (cur_m == DEC) && (cur_d == LAST_OF_DEC);
  assign at_min    = (cur_y == '0) && (cur_m == JAN) && (cur_d == 5'd1);
  assign at_limit  = is_sub ? at_min : at_max;
  assign cnt_full  = &cnt;

  // The current date is a real calendar date while stepping.
  assign cur_ok = (cur_m >= JAN) && (cur_m <= DEC) && (cur_d >= 5'd1) && (cur_d <= ml_cur);

  // One day forward, or one day back for a subtraction.
  always_comb begin
    cur_d_next = cur_d;
    cur_m_next = cur_m;
    cur_y_next = cur_y;
    if (!is_sub) begin
      if (cur_d >= ml_cur) begin
        cur_d_next = 5'd1;
        if (cur_m == DEC) begin
          cur_m_next = JAN;
          cur_y_next = cur_y + 14'd1;
        end else begin
          cur_m_next = cur_m + 4'd1;
        end
      end else begin
        cur_d_next = cur_d + 5'd1;
      end
    end else begin
      if (cur_d > 5'd1) begin
        cur_d_next = cur_d - 5'd1;
      end else if (cur_m == JAN) begin
        cur_d_next = LAST_OF_DEC;
        cur_m_next = DEC;
        cur_y_next = cur_y - 14'd1;
      end else begin
        cur_d_next = ml_prev;
        cur_m_next = cur_m - 4'd1;
      end
    end
  end

  // The difference counts up; add and subtract count the remaining days down.
  assign cnt_less = cnt - CNT_W'(1);
  assign cnt_next = is_diff ? (cnt + CNT_W'(1)) : cnt_less;

  // Difference ends at target or full counter; add/sub at zero count or a limit.
  always_comb begin
    st.res_busy = res_valid;
    if (is_diff) begin
      st.done  = same_date || cnt_full;
      st.limit = !same_date && cnt_full;
    end else begin
      st.done  = (cnt == '0) || at_limit;
      st.limit = (cnt != '0) && at_limit;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_diff <= req_type[gdda_pkg::REQ_DIFF_BIT];
      is_sub  <= (req_type == gdda_pkg::REQ_SUB);
      cur_d   <= day_a;
      cur_m   <= fit_month(month_a);
      cur_y   <= fit_year(year_a);
      tgt_d   <= day_b;
      tgt_m   <= fit_month(month_b);
      tgt_y   <= fit_year(year_b);
      cnt     <= req_type[gdda_pkg::REQ_DIFF_BIT] ? '0 : day_count[CNT_W-1:0];
    end else if (cmd.clamp) begin
      cur_d <= fit_day(cur_d, ml_cur);
      tgt_d <= fit_day(tgt_d, ml_tgt);
    end else if (cmd.order) begin
      if (is_diff && a_after_b) begin
        cur_d <= tgt_d;
        cur_m <= tgt_m;
        cur_y <= tgt_y;
        tgt_d <= cur_d;
        tgt_m <= cur_m;
        tgt_y <= cur_y;
      end
    end else if (cmd.step) begin
      cur_d <= cur_d_next;
      cur_m <= cur_m_next;
      cur_y <= cur_y_next;
      cnt   <= cnt_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.finish) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_day      <= is_diff ? '0 : cur_d;
      res_month    <= is_diff ? '0 : cur_m;
      res_year     <= is_diff ? '0 : cur_y;
      days_apart   <= is_diff ? gdda_pkg::COUNT_W'(cnt) : '0;
      out_of_range <= st.limit;
    end
  end

  `GDDA_ASSERT(a_no_overwrite, cmd.finish, !res_valid || res_ready, "result overwritten")
  `GDDA_ASSERT(a_step_valid_date, cmd.step, cur_ok, "stepping from an invalid date")
  `GDDA_ASSERT_NEXT(a_count_down, cmd.step && !is_diff, cnt == $past(cnt_less), "day counter off")

endmodule

// ===== rtl/gdda_ctrl.sv =====
// ----------------------------------------------------------------------------
// gdda_ctrl
// Sequencer of the date arithmetic block: accepts a request, runs the clamp,
// order and day stepping phases, and hands the outcome to the result register.
// ----------------------------------------------------------------------------
`include "gregorian_date_day_arithmetic_macros.svh"

module gdda_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic              res_ready,
  input  gdda_pkg::status_t st,
  output gdda_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLAMP,
    S_ORDER,
    S_STEP,
    S_DONE
  } state_t;

  state_t state;

  // Command decode.
  always_comb begin
    cmd        = '0;
    cmd.load   = req_valid && req_ready;
    cmd.clamp  = (state == S_CLAMP);
    cmd.order  = (state == S_ORDER);
    cmd.step   = (state == S_STEP) && !st.done;
    cmd.finish = (state == S_DONE) && (!st.res_busy || res_ready);
  end

  // State and the registered ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      req_ready <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state     <= S_CLAMP;
            req_ready <= 1'b0;
          end
        end
        S_CLAMP: begin
          state <= S_ORDER;
        end
        S_ORDER: begin
          state <= S_STEP;
        end
        S_STEP: begin
          if (st.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!st.res_busy || res_ready) begin
            state     <= S_IDLE;
            req_ready <= 1'b1;
          end
        end
        default: begin
          state     <= S_IDLE;
          req_ready <= 1'b1;
        end
      endcase
    end
  end

  `GDDA_ASSERT(a_cmd_onehot, 1'b1, $onehot0({cmd.load, cmd.clamp, cmd.order, cmd.step, cmd.finish}), "more than one datapath command")
  `GDDA_ASSERT(a_ready_idle, 1'b1, req_ready == (state == S_IDLE), "request ready out of step with idle state")

endmodule

// ===== rtl/gregorian_date_day_arithmetic.sv =====
// Gregorian date day arithmetic.
// A request transaction on req carries a code and dates A and B: code 0 adds
// day_count days to A, code 1 subtracts them, codes 2 and 3 give the distance
// in days between A and B. Invalid fields are clamped to the nearest valid
// date. One result transaction on res answers each request.
// After acceptance the sequencer runs its clamp, order, step and done states.
// It steps day_count days, or the distance for a difference, as a single
// date register moves one calendar day per cycle. Add and subtract stop
// early at 0000-01-01 or 9999-12-31, a difference when its day counter fills
// (2^CNT_W - 1, CNT_W the lesser of COUNT_WIDTH and COUNT_W); out_of_range
// then marks the result. Only one request is in flight; the next one is
// taken as soon as the outcome moves into the result register, even while
// that result still waits for res.ready. When res stalls, the finished
// outcome holds inside until the register frees up.
// Synchronous reset returns the sequencer to idle with req.ready high and
// clears res.valid; nothing else needs reset.
// ----------------------------------------------------------------------------
// gregorian_date_day_arithmetic
// Top level: joins the sequencer and the datapath to the two channels.
// ----------------------------------------------------------------------------
module gregorian_date_day_arithmetic #(
  parameter int COUNT_WIDTH = gdda_pkg::COUNT_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  gdda_req_if.sink        req,
  gdda_res_if.source      res
);

  gdda_pkg::cmd_t    cmd;
  gdda_pkg::status_t st;

  gdda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .res_ready (res.ready),
    .st        (st),
    .cmd       (cmd)
  );

  gdda_dpath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .req_type     (req.req_type),
    .day_a        (req.day_a),
    .month_a      (req.month_a),
    .year_a       (req.year_a),
    .day_b        (req.day_b),
    .month_b      (req.month_b),
    .year_b       (req.year_b),
    .day_count    (req.day_count),
    .res_ready    (res.ready),
    .res_valid    (res.valid),
    .res_day      (res.res_day),
    .res_month    (res.res_month),
    .res_year     (res.res_year),
    .days_apart   (res.days_apart),
    .out_of_range (res.out_of_range)
  );

endmodule
